### rtl/voltage_to_multiplexed_seven_segment_unit_defines.svh
// Assertion macros shared by the display driver RTL.
`ifndef VOLTAGE_TO_MULTIPLEXED_SEVEN_SEGMENT_UNIT_DEFINES_SVH
`define VOLTAGE_TO_MULTIPLEXED_SEVEN_SEGMENT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define VMSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vmss_pkg.sv
// Shared constants, types and segment decode for the seven-segment voltmeter driver.
`default_nettype none

package vmss_pkg;

  localparam int REF_W           = 14;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int VALUE_W         = 11;  // scaled value stays below 1639
  localparam int HUND_W          = 5;
  localparam int REM_W           = 7;
  localparam int DIGIT_W         = 4;
  localparam int SEG_W           = 7;
  localparam int DRIVE_W         = 8;
  localparam int EN_W            = 4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Reciprocal constants: x/10, x/100 by multiply and shift, exact over the used ranges.
  localparam int              RECIP_10_W       = 16;
  localparam logic [15:0]     RECIP_10         = 16'd52429;
  localparam int              RECIP_10_SHIFT   = 19;
  localparam int              RECIP_100_W      = 13;
  localparam logic [12:0]     RECIP_100        = 13'd5243;
  localparam int              RECIP_100_SHIFT  = 19;
  localparam int              RECIP_10S_W      = 8;
  localparam logic [7:0]      RECIP_10S        = 8'd205;
  localparam int              RECIP_10S_SHIFT  = 11;

  localparam logic [REF_W-1:0]   REF_RESET       = 14'd3300;
  localparam logic [SEG_W-1:0]   SEG_ZERO        = 7'h7E;
  localparam logic [DRIVE_W-1:0] DRIVE_RESET     = 8'hC8;
  localparam logic [EN_W-1:0]    EN_HUND         = 4'hC;
  localparam logic [EN_W-1:0]    EN_TENS         = 4'hA;
  localparam logic [EN_W-1:0]    EN_ONES         = 4'h6;

  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] value;
  } value_stage_t;

  typedef struct packed {
    logic              cmd;
    logic [HUND_W-1:0] hund;
    logic [REM_W-1:0]  rem;
  } split_stage_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] pat;
    unique case (digit)
      4'd0:    pat = 7'h7E;
      4'd1:    pat = 7'h48;
      4'd2:    pat = 7'h3D;
      4'd3:    pat = 7'h6D;
      4'd4:    pat = 7'h4B;
      4'd5:    pat = 7'h67;
      4'd6:    pat = 7'h77;
      4'd7:    pat = 7'h4C;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = SEG_ZERO;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

### rtl/voltage_to_multiplexed_seven_segment_unit.sv
// Three-digit voltmeter display driver: scan sequencer over a scaled converter sample.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries command_i and sample_i. A command of
//   0 loads a converter sample; it is scaled by the reference millivolts to units of
//   10 mV and its three digit patterns are stored. A command of 1 is a scan tick that
//   steps the display through hundreds (decimal point on), tens and ones.
//   Output channel (out_valid_o / out_stall_i) returns one transaction per input
//   transaction: segment_drive_o and active-low digit_enable_n_o after that item.
//   out_valid_o rises once the transaction has passed the multiply, reciprocal divide,
//   digit split and scan output registers; one item per cycle is taken sustained while
//   out_stall_i does not hold the output.
//   When the output transaction is stalled the whole pipeline holds and in_stall_o rises.
//   cfg_we_i writes cfg_wdata_i into the reference register; write only while idle.
//   Reset: reference 3300 mV, all digits show 0, drive 0xC8 / 0x6, scan at hundreds.
`default_nettype none

module voltage_to_multiplexed_seven_segment_unit #(
  parameter int SAMPLE_BITS = vmss_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [vmss_pkg::REF_W-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         command_i,
  input  wire logic [SAMPLE_BITS-1:0]       sample_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [vmss_pkg::DRIVE_W-1:0]      segment_drive_o,
  output logic [vmss_pkg::EN_W-1:0]         digit_enable_n_o
);

  logic [vmss_pkg::REF_W-1:0] ref_q;
  logic                       adv;
  logic                       val_valid;
  vmss_pkg::value_stage_t     val_stage;
  logic                       split_valid;
  vmss_pkg::split_stage_t     split_stage;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= vmss_pkg::REF_RESET;
    end else if (cfg_we_i) begin
      ref_q <= cfg_wdata_i;
    end
  end

  // pipeline moves whenever the output slot is empty or being taken
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  vmss_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (in_valid_i),
    .command_i (command_i),
    .sample_i  (sample_i),
    .ref_i     (ref_q),
    .valid_o   (val_valid),
    .stage_o   (val_stage)
  );

  vmss_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (val_valid),
    .stage_i (val_stage),
    .valid_o (split_valid),
    .stage_o (split_stage)
  );

  vmss_scan u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .valid_i          (split_valid),
    .stage_i          (split_stage),
    .out_valid_o      (out_valid_o),
    .segment_drive_o  (segment_drive_o),
    .digit_enable_n_o (digit_enable_n_o)
  );

endmodule

`default_nettype wire

### rtl/vmss_scale.sv
// Scaling stages: sample times reference, then divide by 10 * 2^SAMPLE_BITS.
`default_nettype none

module vmss_scale #(
  parameter int SAMPLE_BITS = vmss_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire logic                         valid_i,
  input  wire logic                         command_i,
  input  wire logic [SAMPLE_BITS-1:0]       sample_i,
  input  wire logic [vmss_pkg::REF_W-1:0]   ref_i,
  output logic                              valid_o,
  output vmss_pkg::value_stage_t            stage_o
);

  localparam int PROD_W = SAMPLE_BITS + vmss_pkg::REF_W;
  localparam int QUOT_W = vmss_pkg::REF_W + vmss_pkg::RECIP_10_W;

  logic              prod_valid_q;
  logic              prod_cmd_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;
  logic [vmss_pkg::REF_W-1:0] scaled;
  logic [QUOT_W-1:0] quot_full;
  logic              val_valid_q;
  vmss_pkg::value_stage_t val_q;
  vmss_pkg::value_stage_t val_d;

  assign prod_d = PROD_W'(sample_i) * PROD_W'(ref_i);

  // floor(floor(P / 10) / 2^N) == floor((P >> N) / 10)
  assign scaled    = prod_q[SAMPLE_BITS +: vmss_pkg::REF_W];
  assign quot_full = QUOT_W'(scaled) * QUOT_W'(vmss_pkg::RECIP_10);

  always_comb begin
    val_d.cmd   = prod_cmd_q;
    val_d.value = quot_full[vmss_pkg::RECIP_10_SHIFT +: vmss_pkg::VALUE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      val_valid_q  <= 1'b0;
    end else if (adv_i) begin
      prod_valid_q <= valid_i;
      val_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_cmd_q <= command_i;
      prod_q     <= prod_d;
      val_q      <= val_d;
    end
  end

  assign valid_o = val_valid_q;
  assign stage_o = val_q;

endmodule

`default_nettype wire

### rtl/vmss_digits.sv
// Digit split stage: hundreds digit and the remainder below one hundred.
`default_nettype none

module vmss_digits (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   adv_i,
  input  wire logic                   valid_i,
  input  wire vmss_pkg::value_stage_t stage_i,
  output logic                        valid_o,
  output vmss_pkg::split_stage_t      stage_o
);

  localparam int HPROD_W = vmss_pkg::VALUE_W + vmss_pkg::RECIP_100_W;

  logic [HPROD_W-1:0]           hund_full;
  logic [vmss_pkg::HUND_W-1:0]  hund;
  logic [vmss_pkg::VALUE_W-1:0] hund_x100;
  logic [vmss_pkg::VALUE_W-1:0] rem_full;
  logic                         split_valid_q;
  vmss_pkg::split_stage_t       split_q;
  vmss_pkg::split_stage_t       split_d;

  assign hund_full = HPROD_W'(stage_i.value) * HPROD_W'(vmss_pkg::RECIP_100);
  assign hund      = hund_full[vmss_pkg::RECIP_100_SHIFT +: vmss_pkg::HUND_W];
  assign hund_x100 = vmss_pkg::VALUE_W'(hund) * vmss_pkg::VALUE_W'(100);
  assign rem_full  = stage_i.value - hund_x100;

  always_comb begin
    split_d.cmd  = stage_i.cmd;
    split_d.hund = hund;
    split_d.rem  = rem_full[vmss_pkg::REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_valid_q <= 1'b0;
    end else if (adv_i) begin
      split_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      split_q <= split_d;
    end
  end

  assign valid_o = split_valid_q;
  assign stage_o = split_q;

endmodule

`default_nettype wire

### rtl/vmss_scan.sv
// Final stage: digit pattern store, scan sequencer and the output drive registers.
`default_nettype none
`include "voltage_to_multiplexed_seven_segment_unit_defines.svh"

module vmss_scan (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           adv_i,
  input  wire logic                           valid_i,
  input  wire vmss_pkg::split_stage_t         stage_i,
  output logic                                out_valid_o,
  output logic [vmss_pkg::DRIVE_W-1:0]        segment_drive_o,
  output logic [vmss_pkg::EN_W-1:0]           digit_enable_n_o
);

  typedef enum logic [1:0] {
    POS_HUND = 2'd0,
    POS_TENS = 2'd1,
    POS_ONES = 2'd2
  } scan_pos_e;

  localparam int TPROD_W = vmss_pkg::REM_W + vmss_pkg::RECIP_10S_W;

  logic [TPROD_W-1:0]              tens_full;
  logic [vmss_pkg::DIGIT_W-1:0]    tens;
  logic [vmss_pkg::REM_W-1:0]      tens_x10;
  logic [vmss_pkg::REM_W-1:0]      ones_full;
  logic [vmss_pkg::DIGIT_W-1:0]    ones;

  scan_pos_e                       pos_q;
  logic [vmss_pkg::SEG_W-1:0]      hund_pat_q;
  logic [vmss_pkg::SEG_W-1:0]      tens_pat_q;
  logic [vmss_pkg::SEG_W-1:0]      ones_pat_q;
  logic [vmss_pkg::DRIVE_W-1:0]    seg_q;
  logic [vmss_pkg::EN_W-1:0]       en_q;
  logic                            out_valid_q;

  assign tens_full = TPROD_W'(stage_i.rem) * TPROD_W'(vmss_pkg::RECIP_10S);
  assign tens      = tens_full[vmss_pkg::RECIP_10S_SHIFT +: vmss_pkg::DIGIT_W];
  assign tens_x10  = vmss_pkg::REM_W'(tens) * vmss_pkg::REM_W'(10);
  assign ones_full = stage_i.rem - tens_x10;
  assign ones      = ones_full[vmss_pkg::DIGIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_HUND;
      hund_pat_q  <= vmss_pkg::SEG_ZERO;
      tens_pat_q  <= vmss_pkg::SEG_ZERO;
      ones_pat_q  <= vmss_pkg::SEG_ZERO;
      seg_q       <= vmss_pkg::DRIVE_RESET;
      en_q        <= vmss_pkg::EN_ONES;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= valid_i;
      if (valid_i) begin
        if (stage_i.cmd == vmss_pkg::CMD_SAMPLE) begin
          // hundreds can exceed nine only with an out-of-range reference
          if (stage_i.hund < vmss_pkg::HUND_W'(10)) begin
            hund_pat_q <= vmss_pkg::seg_pattern(stage_i.hund[vmss_pkg::DIGIT_W-1:0]);
          end
          tens_pat_q <= vmss_pkg::seg_pattern(tens);
          ones_pat_q <= vmss_pkg::seg_pattern(ones);
        end else begin
          unique case (pos_q)
            POS_HUND: begin
              en_q  <= vmss_pkg::EN_HUND;
              seg_q <= {1'b1, hund_pat_q};
              pos_q <= POS_TENS;
            end
            POS_TENS: begin
              en_q  <= vmss_pkg::EN_TENS;
              seg_q <= {1'b0, tens_pat_q};
              pos_q <= POS_ONES;
            end
            POS_ONES: begin
              en_q  <= vmss_pkg::EN_ONES;
              seg_q <= {1'b0, ones_pat_q};
              pos_q <= POS_HUND;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign segment_drive_o  = seg_q;
  assign digit_enable_n_o = en_q;

  `VMSS_ASSERT_NEXT(a_sample_keeps_drive, clk_i, rst_ni,
    adv_i && valid_i && stage_i.cmd == vmss_pkg::CMD_SAMPLE,
    $stable(seg_q) && $stable(en_q), "sample transaction changed the drive")
  `VMSS_ASSERT_NEXT(a_hund_has_dp, clk_i, rst_ni,
    adv_i && valid_i && stage_i.cmd == vmss_pkg::CMD_TICK && pos_q == POS_HUND,
    seg_q[vmss_pkg::DRIVE_W-1] && en_q == vmss_pkg::EN_HUND, "hundreds drive wrong")
  `VMSS_ASSERT_NOW(a_pos_matches_enable, clk_i, rst_ni, 1'b1,
    ((pos_q == POS_HUND) == (en_q == vmss_pkg::EN_ONES)) &&
    ((pos_q == POS_TENS) == (en_q == vmss_pkg::EN_HUND)) &&
    ((pos_q == POS_ONES) == (en_q == vmss_pkg::EN_TENS)), "scan position out of step")

endmodule

`default_nettype wire
